// ===== rtl/dpa_pkg.sv =====
// Shared constants, codes and controller/datapath types of the descriptor page allocator.
`default_nettype none

package dpa_pkg;

    localparam int DEF_NUM_PAGES  = 16;
    localparam int DEF_FENCE_BITS = 32;

    localparam int CMD_W      = 2;
    localparam int COUNT_W    = 9;
    localparam int FENCE_W    = 32;
    localparam int SLOT_W     = 16;
    localparam int ERR_W      = 2;
    localparam int PWORDS_W   = 9;
    localparam int PSLOTS_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_ALLOC_DYN  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC_PERS = 2'd2;

    localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_NO_PAGE  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_PERS_FULL = 2'd2;
    localparam logic [ERR_W-1:0] ERR_OVERSIZE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_WORDS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERSISTENT_SLOTS = 2'd1;

    localparam logic [PWORDS_W-1:0] PAGE_WORDS_RST       = 9'd64;
    localparam logic [PSLOTS_W-1:0] PERSISTENT_SLOTS_RST = 16'd1024;

    // datapath micro-operations
    typedef logic [3:0] t_dp_op;
    localparam t_dp_op OP_NONE         = 4'd0;
    localparam t_dp_op OP_PERSIST      = 4'd1;
    localparam t_dp_op OP_RES_ZERO     = 4'd2;
    localparam t_dp_op OP_RES_OVERSIZE = 4'd3;
    localparam t_dp_op OP_RES_NOPAGE   = 4'd4;
    localparam t_dp_op OP_RETIRE       = 4'd5;
    localparam t_dp_op OP_REL_RD       = 4'd6;
    localparam t_dp_op OP_REL_WR       = 4'd7;
    localparam t_dp_op OP_REL_END      = 4'd8;
    localparam t_dp_op OP_DRN_RD       = 4'd9;
    localparam t_dp_op OP_DRN_WR       = 4'd10;
    localparam t_dp_op OP_POP_RD       = 4'd11;
    localparam t_dp_op OP_POP_WR       = 4'd12;
    localparam t_dp_op OP_MUL          = 4'd13;
    localparam t_dp_op OP_FIN          = 4'd14;

    typedef struct packed {
        logic   latch;
        logic   load_out;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             too_big;
        logic             fits;
        logic             free_empty;
        logic             drain_more;
        logic             drain_ok;
        logic             rel_more;
        logic             out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/dpa_intf.sv =====
// Request, response and configuration channel interfaces.
`default_nettype none

interface dpa_req_if import dpa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [COUNT_W-1:0] count;
    logic [FENCE_W-1:0] fence_value;
    logic [FENCE_W-1:0] completed_value;

    modport source (output valid, command, count, fence_value, completed_value, input ready);
    modport sink   (input valid, command, count, fence_value, completed_value, output ready);
endinterface

interface dpa_rsp_if import dpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot_index;
    logic [ERR_W-1:0]  error_code;

    modport source (output valid, slot_index, error_code, input ready);
    modport sink   (input valid, slot_index, error_code, output ready);
endinterface

interface dpa_cfg_if import dpa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/descriptor_page_allocator_unit.sv =====
// Descriptor page allocator: top level joining the sequencer and the datapath.
// One request word is worked at a time. The response sits in an output register, so a new
// request is taken while the last response waits. The paths through the sequencer:
//   - unused command, persistent allocation or oversize count: result, then output;
//   - dynamic allocation in the current page: multiply, finish, output;
//   - dynamic allocation with a fresh page from the stack: retire, stack read and pop, then as above;
//   - with the free stack empty, pages are first recycled from the release FIFO, a read and
//     a write each, until the FIFO is empty, the stack is full or a page whose fence is not yet
//     complete stops the recycling; if no page comes free, the no-page response follows;
//   - release: a read and a write per used page, then the output.
// A response that cannot enter the output register holds the sequencer until it is free.
// The sequencer steps one memory access per cycle on the page stack, release FIFO and used
// list. No clearing pass after reset: the block is ready at once.
`default_nettype none

module descriptor_page_allocator_unit import dpa_pkg::*; #(
    parameter int NUM_PAGES  = DEF_NUM_PAGES,
    parameter int FENCE_BITS = DEF_FENCE_BITS
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    dpa_req_if.sink   i_req,
    dpa_rsp_if.source o_rsp,
    dpa_cfg_if.sink   i_cfg
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_req_ready;

    assign i_req.ready = w_req_ready;
    assign i_cfg.ready = 1'b1;

    dpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_sts       (w_sts),
        .o_req_ready (w_req_ready),
        .o_cmd       (w_cmd)
    );

    dpa_dp #(
        .NUM_PAGES  (NUM_PAGES),
        .FENCE_BITS (FENCE_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_command         (i_req.command),
        .i_count           (i_req.count),
        .i_fence_value     (i_req.fence_value),
        .i_completed_value (i_req.completed_value),
        .i_cfg_valid       (i_cfg.valid),
        .i_cfg_index       (i_cfg.index),
        .i_cfg_data        (i_cfg.data),
        .i_rsp_ready       (o_rsp.ready),
        .o_rsp_valid       (o_rsp.valid),
        .o_slot_index      (o_rsp.slot_index),
        .o_error_code      (o_rsp.error_code)
    );

    a_accept_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |-> w_cmd.latch)
        else $error("request accepted without latch");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> w_sts.out_free)
        else $error("response loaded over a pending word");

    a_rise_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(w_cmd.load_out))
        else $error("response valid without a load");

    a_err_zero_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.error_code != ERR_OK)) |-> (o_rsp.slot_index == '0))
        else $error("nonzero slot on error response");

endmodule

`default_nettype wire

// ===== rtl/dpa_ctrl.sv =====
// Command sequencer: steps the datapath through each request word.
`default_nettype none

module dpa_ctrl import dpa_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_req_valid,
    input  wire t_dp_sts i_sts,
    output logic         o_req_ready,
    output t_dp_cmd      o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_REL     = 4'd2;
    localparam logic [3:0] S_REL_WR  = 4'd3;
    localparam logic [3:0] S_DRN_RD  = 4'd4;
    localparam logic [3:0] S_DRN_CHK = 4'd5;
    localparam logic [3:0] S_POP_CHK = 4'd6;
    localparam logic [3:0] S_POP_WR  = 4'd7;
    localparam logic [3:0] S_MUL     = 4'd8;
    localparam logic [3:0] S_FIN     = 4'd9;
    localparam logic [3:0] S_OUT     = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state        = r_state;
        o_cmd.latch    = 1'b0;
        o_cmd.load_out = 1'b0;
        o_cmd.op       = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.command)
                    CMD_ALLOC_DYN: begin
                        if (i_sts.too_big) begin
                            o_cmd.op = OP_RES_OVERSIZE;
                            n_state  = S_OUT;
                        end else if (i_sts.fits) begin
                            n_state = S_MUL;
                        end else begin
                            // retire current page; recycle only if the stack is dry
                            o_cmd.op = OP_RETIRE;
                            n_state  = i_sts.free_empty ? S_DRN_RD : S_POP_CHK;
                        end
                    end
                    CMD_RELEASE: n_state = S_REL;
                    CMD_ALLOC_PERS: begin
                        o_cmd.op = OP_PERSIST;
                        n_state  = S_OUT;
                    end
                    default: begin
                        o_cmd.op = OP_RES_ZERO;
                        n_state  = S_OUT;
                    end
                endcase
            end
            S_REL: begin
                if (i_sts.rel_more) begin
                    o_cmd.op = OP_REL_RD;
                    n_state  = S_REL_WR;
                end else begin
                    o_cmd.op = OP_REL_END;
                    n_state  = S_OUT;
                end
            end
            S_REL_WR: begin
                o_cmd.op = OP_REL_WR;
                n_state  = S_REL;
            end
            S_DRN_RD: begin
                if (i_sts.drain_more) begin
                    o_cmd.op = OP_DRN_RD;
                    n_state  = S_DRN_CHK;
                end else begin
                    n_state = S_POP_CHK;
                end
            end
            S_DRN_CHK: begin
                if (i_sts.drain_ok) begin
                    o_cmd.op = OP_DRN_WR;
                    n_state  = S_DRN_RD;
                end else begin
                    n_state = S_POP_CHK;
                end
            end
            S_POP_CHK: begin
                if (i_sts.free_empty) begin
                    o_cmd.op = OP_RES_NOPAGE;
                    n_state  = S_OUT;
                end else begin
                    o_cmd.op = OP_POP_RD;
                    n_state  = S_POP_WR;
                end
            end
            S_POP_WR: begin
                o_cmd.op = OP_POP_WR;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_FIN;
            end
            S_FIN: begin
                o_cmd.op = OP_FIN;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/dpa_dp.sv =====
// Datapath: config registers, page stack, release FIFO, used list, counters and result.
`default_nettype none

module dpa_dp import dpa_pkg::*; #(
    parameter int NUM_PAGES  = DEF_NUM_PAGES,
    parameter int FENCE_BITS = DEF_FENCE_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts,
    input  wire logic [CMD_W-1:0]      i_command,
    input  wire logic [COUNT_W-1:0]    i_count,
    input  wire logic [FENCE_W-1:0]    i_fence_value,
    input  wire logic [FENCE_W-1:0]    i_completed_value,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_rsp_ready,
    output logic                       o_rsp_valid,
    output logic [SLOT_W-1:0]          o_slot_index,
    output logic [ERR_W-1:0]           o_error_code
);

    localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CW = $clog2(NUM_PAGES + 1);
    localparam int FW = (FENCE_BITS < FENCE_W) ? FENCE_BITS : FENCE_W;
    localparam logic [CW-1:0] N_PAGES   = CW'(NUM_PAGES);
    localparam logic [PW-1:0] LAST_PAGE = PW'(NUM_PAGES - 1);

    // configuration
    logic [PWORDS_W-1:0] r_page_words;
    logic [PSLOTS_W-1:0] r_pers_slots;

    // latched request word
    logic [CMD_W-1:0]   r_command;
    logic [COUNT_W-1:0] r_count;
    logic [FW-1:0]      r_fence;
    logic [FW-1:0]      r_completed;

    // memories
    logic [PW-1:0] r_stack_mem [NUM_PAGES];
    logic [PW-1:0] r_used_mem  [NUM_PAGES];
    logic [PW-1:0] r_fpage_mem [NUM_PAGES];
    logic [FW-1:0] r_ffence_mem[NUM_PAGES];
    logic [NUM_PAGES-1:0] r_stk_written;

    // bookkeeping
    logic [CW-1:0]       r_free_cnt;
    logic [CW-1:0]       r_fifo_cnt;
    logic [CW-1:0]       r_used_cnt;
    logic [CW-1:0]       r_rel_idx;
    logic [PW-1:0]       r_head;
    logic [PW-1:0]       r_tail;
    logic [PW-1:0]       r_cur_page;
    logic                r_cur_valid;
    logic [PWORDS_W-1:0] r_offset;
    logic [PSLOTS_W-1:0] r_pers_next;

    // registered read data and result
    logic [PW-1:0]      r_stk_q;
    logic               r_stk_vld;
    logic [PW-1:0]      r_stk_addr;
    logic [PW-1:0]      r_used_q;
    logic [PW-1:0]      r_fq_page;
    logic [FW-1:0]      r_fq_fence;
    logic [PW+8:0]      r_prod;
    logic [SLOT_W-1:0]  r_res_slot;
    logic [ERR_W-1:0]   r_res_err;
    logic               r_out_valid;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [ERR_W-1:0]   r_out_err;

    logic [CW-1:0]       w_free_dec;
    logic [PW-1:0]       w_pop_addr;
    logic [PWORDS_W:0]   w_fit_sum;
    logic [PW-1:0]       w_head_nxt;
    logic [PW-1:0]       w_tail_nxt;

    assign w_free_dec = r_free_cnt - CW'(1);
    assign w_pop_addr = w_free_dec[PW-1:0];
    assign w_fit_sum  = {1'b0, r_offset} + {1'b0, r_count};
    assign w_head_nxt = (r_head == LAST_PAGE) ? '0 : r_head + PW'(1);
    assign w_tail_nxt = (r_tail == LAST_PAGE) ? '0 : r_tail + PW'(1);

    assign o_sts.command    = r_command;
    assign o_sts.too_big    = (r_count > r_page_words);
    assign o_sts.fits       = r_cur_valid && (w_fit_sum <= {1'b0, r_page_words});
    assign o_sts.free_empty = (r_free_cnt == '0);
    assign o_sts.drain_more = (r_fifo_cnt != '0) && (r_free_cnt < N_PAGES);
    assign o_sts.drain_ok   = (r_fq_fence <= r_completed);
    assign o_sts.rel_more   = (r_rel_idx < r_used_cnt);
    assign o_sts.out_free   = !r_out_valid || i_rsp_ready;

    assign o_rsp_valid  = r_out_valid;
    assign o_slot_index = r_out_slot;
    assign o_error_code = r_out_err;

    // memories and payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_command   <= i_command;
            r_count     <= i_count;
            r_fence     <= i_fence_value[FW-1:0];
            r_completed <= i_completed_value[FW-1:0];
        end
        case (i_cmd.op)
            OP_RETIRE: begin
                if (r_cur_valid && (r_used_cnt < N_PAGES)) begin
                    r_used_mem[r_used_cnt[PW-1:0]] <= r_cur_page;
                end
            end
            OP_REL_RD: r_used_q <= r_used_mem[r_rel_idx[PW-1:0]];
            OP_REL_WR: begin
                if (r_fifo_cnt < N_PAGES) begin
                    r_fpage_mem[r_tail]  <= r_used_q;
                    r_ffence_mem[r_tail] <= r_fence;
                end
            end
            OP_DRN_RD: begin
                r_fq_page  <= r_fpage_mem[r_head];
                r_fq_fence <= r_ffence_mem[r_head];
            end
            OP_DRN_WR: r_stack_mem[r_free_cnt[PW-1:0]] <= r_fq_page;
            OP_POP_RD: begin
                r_stk_q    <= r_stack_mem[w_pop_addr];
                r_stk_vld  <= r_stk_written[w_pop_addr];
                r_stk_addr <= w_pop_addr;
            end
            OP_MUL: begin
                r_prod <= {{PWORDS_W{1'b0}}, r_cur_page} * {{PW{1'b0}}, r_page_words};
            end
            OP_PERSIST: begin
                if (r_pers_next >= r_pers_slots) begin
                    r_res_slot <= '0;
                    r_res_err  <= ERR_PERS_FULL;
                end else begin
                    r_res_slot <= r_pers_next;
                    r_res_err  <= ERR_OK;
                end
            end
            OP_RES_ZERO, OP_REL_END: begin
                r_res_slot <= '0;
                r_res_err  <= ERR_OK;
            end
            OP_RES_OVERSIZE: begin
                r_res_slot <= '0;
                r_res_err  <= ERR_OVERSIZE;
            end
            OP_RES_NOPAGE: begin
                r_res_slot <= '0;
                r_res_err  <= ERR_NO_PAGE;
            end
            OP_FIN: begin
                r_res_slot <= r_pers_slots + SLOT_W'(r_prod) + SLOT_W'(r_offset);
                r_res_err  <= ERR_OK;
            end
            default: ;
        endcase
        if (i_cmd.load_out) begin
            r_out_slot <= r_res_slot;
            r_out_err  <= r_res_err;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_words  <= PAGE_WORDS_RST;
            r_pers_slots  <= PERSISTENT_SLOTS_RST;
            r_stk_written <= '0;
            r_free_cnt    <= N_PAGES;
            r_fifo_cnt    <= '0;
            r_used_cnt    <= '0;
            r_rel_idx     <= '0;
            r_head        <= '0;
            r_tail        <= '0;
            r_cur_page    <= '0;
            r_cur_valid   <= 1'b0;
            r_offset      <= '0;
            r_pers_next   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_PAGE_WORDS:       r_page_words <= i_cfg_data[PWORDS_W-1:0];
                    CFG_PERSISTENT_SLOTS: r_pers_slots <= i_cfg_data;
                    default: ;
                endcase
            end
            case (i_cmd.op)
                OP_PERSIST: begin
                    if (r_pers_next < r_pers_slots) begin
                        r_pers_next <= r_pers_next + PSLOTS_W'(1);
                    end
                end
                OP_RETIRE: begin
                    if (r_cur_valid && (r_used_cnt < N_PAGES)) begin
                        r_used_cnt <= r_used_cnt + CW'(1);
                    end
                    r_cur_valid <= 1'b0;
                end
                OP_REL_RD: r_rel_idx <= r_rel_idx + CW'(1);
                OP_REL_WR: begin
                    if (r_fifo_cnt < N_PAGES) begin
                        r_tail     <= w_tail_nxt;
                        r_fifo_cnt <= r_fifo_cnt + CW'(1);
                    end
                end
                OP_REL_END: begin
                    r_used_cnt <= '0;
                    r_rel_idx  <= '0;
                end
                OP_DRN_WR: begin
                    r_stk_written[r_free_cnt[PW-1:0]] <= 1'b1;
                    r_free_cnt <= r_free_cnt + CW'(1);
                    r_head     <= w_head_nxt;
                    r_fifo_cnt <= r_fifo_cnt - CW'(1);
                end
                OP_POP_RD: r_free_cnt <= w_free_dec;
                OP_POP_WR: begin
                    // never-written stack entries hold their own page number
                    r_cur_page  <= r_stk_vld ? r_stk_q : r_stk_addr;
                    r_cur_valid <= 1'b1;
                    r_offset    <= '0;
                end
                OP_FIN: r_offset <= PWORDS_W'(w_fit_sum);
                default: ;
            endcase
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_descriptor_page_allocator_unit.sv =====
// Self-checking testbench for the descriptor page allocator unit.
module tb_descriptor_page_allocator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import dpa_pkg::*;

    localparam int PAGES      = DEF_NUM_PAGES;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_LONG  = 300;

    localparam logic [CMD_W-1:0]     CMD_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [ERR_W-1:0]  err;
    } t_slot_grant;

    typedef enum logic [1:0] {RX_STEADY, RX_LIGHT, RX_HEAVY, RX_EVERY_THIRD} t_rx_pattern;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dpa_req_if req_if();
    dpa_rsp_if rsp_if();
    dpa_cfg_if cfg_if();

    descriptor_page_allocator_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // allocator shadow state
    logic [PWORDS_W-1:0] page_words_cfg;
    logic [PSLOTS_W-1:0] persist_slots_cfg;
    logic [3:0]          free_stack [PAGES];
    int                  free_cnt;
    logic [3:0]          recycle_page [PAGES];
    logic [FENCE_W-1:0]  recycle_fence [PAGES];
    int                  recycle_head;
    int                  recycle_tail;
    int                  recycle_cnt;
    logic [3:0]          used_pages [PAGES];
    int                  used_cnt;
    logic                cur_valid;
    logic [3:0]          cur_page;
    int                  page_offset;
    logic [SLOT_W-1:0]   persist_next;

    t_slot_grant slot_grants_due[$];

    int  fail_count = 0;
    int  cmd_seen[4];
    int  err_seen[4];
    int  reg_writes = 0;
    int  burst_left = 0;
    bit  gaps_off = 1'b0;
    int  hold_asks = 0;
    int  hold_length = 0;
    logic [FENCE_W-1:0] fence_now;
    logic [FENCE_W-1:0] fence_done;

    function automatic void reset_allocator_model();
        page_words_cfg    = PAGE_WORDS_RST;
        persist_slots_cfg = PERSISTENT_SLOTS_RST;
        for (int i = 0; i < PAGES; i++) begin
            free_stack[i]    = i[3:0];
            recycle_page[i]  = '0;
            recycle_fence[i] = '0;
            used_pages[i]    = '0;
        end
        free_cnt     = PAGES;
        recycle_head = 0;
        recycle_tail = 0;
        recycle_cnt  = 0;
        used_cnt     = 0;
        cur_valid    = 1'b0;
        cur_page     = '0;
        page_offset  = 0;
        persist_next = '0;
    endfunction

    function automatic void predict_allocation(input logic [CMD_W-1:0] cmd,
                                               input logic [COUNT_W-1:0] cnt,
                                               input logic [FENCE_W-1:0] fence,
                                               input logic [FENCE_W-1:0] comp,
                                               output t_slot_grant grant);
        int sum;
        grant.slot = '0;
        grant.err  = ERR_OK;
        case (cmd)
            CMD_ALLOC_DYN: begin
                if (cnt > page_words_cfg) begin
                    grant.err = ERR_OVERSIZE;
                end else begin
                    if (!cur_valid || page_offset + int'(cnt) > int'(page_words_cfg)) begin
                        if (cur_valid && used_cnt < PAGES) begin
                            used_pages[used_cnt] = cur_page;
                            used_cnt++;
                        end
                        cur_valid = 1'b0;
                        // recycle only once the stack has run dry
                        if (free_cnt == 0) begin
                            while (recycle_cnt > 0 && free_cnt < PAGES &&
                                   recycle_fence[recycle_head] <= comp) begin
                                free_stack[free_cnt] = recycle_page[recycle_head];
                                free_cnt++;
                                recycle_head = (recycle_head + 1) % PAGES;
                                recycle_cnt--;
                            end
                        end
                        if (free_cnt != 0) begin
                            free_cnt--;
                            cur_page    = free_stack[free_cnt];
                            cur_valid   = 1'b1;
                            page_offset = 0;
                        end
                    end
                    if (!cur_valid) begin
                        grant.err = ERR_NO_PAGE;
                    end else begin
                        sum = int'(persist_slots_cfg) + int'(cur_page) * int'(page_words_cfg)
                              + page_offset;
                        grant.slot  = sum[SLOT_W-1:0];
                        page_offset = page_offset + int'(cnt);
                    end
                end
            end
            CMD_RELEASE: begin
                for (int i = 0; i < used_cnt && recycle_cnt < PAGES; i++) begin
                    recycle_page[recycle_tail]  = used_pages[i];
                    recycle_fence[recycle_tail] = fence;
                    recycle_tail = (recycle_tail + 1) % PAGES;
                    recycle_cnt++;
                end
                used_cnt = 0;
            end
            CMD_ALLOC_PERS: begin
                if (persist_next >= persist_slots_cfg) begin
                    grant.err = ERR_PERS_FULL;
                end else begin
                    grant.slot   = persist_next;
                    persist_next = persist_next + 16'd1;
                end
            end
            default: ;
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [COUNT_W-1:0] cnt,
                             input logic [FENCE_W-1:0] fence, input logic [FENCE_W-1:0] comp);
        t_slot_grant grant;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gaps_off)
                gap = 0;
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        req_if.valid           <= 1'b1;
        req_if.command         <= cmd;
        req_if.count           <= cnt;
        req_if.fence_value     <= fence;
        req_if.completed_value <= comp;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        predict_allocation(cmd, cnt, fence, comp, grant);
        slot_grants_due = {slot_grants_due, grant};
        cmd_seen[cmd]++;
        @(negedge i_clk);
    endtask

    task automatic wait_until_idle();
        req_if.valid <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (slot_grants_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wait_until_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        case (idx)
            CFG_PAGE_WORDS:       page_words_cfg = data[PWORDS_W-1:0];
            CFG_PERSISTENT_SLOTS: persist_slots_cfg = data;
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // tidy words follow a sane fence order; the rest is noise over the full field ranges
    task automatic send_random_word(input bit tidy);
        logic [CMD_W-1:0]   cmd;
        logic [COUNT_W-1:0] cnt;
        logic [FENCE_W-1:0] fence;
        logic [FENCE_W-1:0] comp;
        int unsigned roll;
        int unsigned top;
        top = int'(page_words_cfg);
        if (tidy) begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                cmd = CMD_ALLOC_DYN;
            else if (roll < 75)
                cmd = CMD_RELEASE;
            else if (roll < 97)
                cmd = CMD_ALLOC_PERS;
            else
                cmd = CMD_UNUSED;
            roll = $urandom_range(0, 9);
            if (top == 0 || roll == 0)
                cnt = '0;
            else if (roll < 6)
                cnt = COUNT_W'($urandom_range(1, (top < 16) ? top : 16));
            else if (roll < 9)
                cnt = COUNT_W'($urandom_range(1, (top > 511) ? 511 : top));
            else
                cnt = COUNT_W'(top);
            if (cmd == CMD_RELEASE) begin
                fence_now = fence_now + FENCE_W'($urandom_range(1, 3));
                fence = fence_now;
            end else begin
                fence = $urandom();
            end
            roll = $urandom_range(0, 19);
            if (roll < 6)
                fence_done = fence_now;
            comp = (roll == 19) ? '1 : fence_done;
        end else begin
            cmd   = CMD_W'($urandom_range(0, 3));
            cnt   = COUNT_W'($urandom_range(0, 511));
            fence = $urandom();
            comp  = $urandom();
        end
        send_word(cmd, cnt, fence, comp);
    endtask

    task automatic test_directed_cases();
        send_word(CMD_UNUSED, '1, '1, '1);
        send_word(CMD_ALLOC_DYN, 9'd0, $urandom(), $urandom());   // takes a page
        send_word(CMD_ALLOC_DYN, 9'd0, $urandom(), $urandom());   // offset stays put
        send_word(CMD_ALLOC_DYN, 9'd64, $urandom(), $urandom());  // exact fit
        send_word(CMD_ALLOC_DYN, 9'd65, $urandom(), $urandom());
        send_word(CMD_ALLOC_DYN, '1, $urandom(), $urandom());
        send_word(CMD_ALLOC_DYN, 9'd1, $urandom(), $urandom());   // page turnover
        send_word(CMD_ALLOC_PERS, '0, '0, '0);
        send_word(CMD_ALLOC_PERS, '1, $urandom(), $urandom());
        send_word(CMD_RELEASE, 9'd3, '1, '0);
        write_reg(CFG_PERSISTENT_SLOTS, 16'd2);
        send_word(CMD_ALLOC_PERS, 9'd1, $urandom(), $urandom());
        write_reg(CFG_PERSISTENT_SLOTS, 16'd0);
        send_word(CMD_ALLOC_PERS, 9'd1, $urandom(), $urandom());
        write_reg(CFG_PAGE_WORDS, 16'd32);
        write_reg(CFG_PERSISTENT_SLOTS, 16'd32768);
        // run the stack dry; the queued page is fenced past completion
        repeat (14)
            send_word(CMD_ALLOC_DYN, 9'd32, $urandom(), 32'hFFFF_FFFE);
        send_word(CMD_RELEASE, 9'd0, 32'd5, $urandom());
        send_word(CMD_ALLOC_DYN, 9'd1, $urandom(), 32'd4);
        send_word(CMD_ALLOC_DYN, 9'd1, $urandom(), '1);
        write_reg(CFG_PAGE_WORDS, 16'd1);
        send_word(CMD_ALLOC_DYN, 9'd1, $urandom(), '1);
    endtask

    task automatic test_register_settings();
        logic [PWORDS_W-1:0] pw_set [5];
        logic [PSLOTS_W-1:0] ps_set [5];
        pw_set = '{9'd256, 9'd511, 9'd1, 9'd0, 9'd32};
        ps_set = '{16'hFFFF, 16'h0000, 16'h8000, 16'd7, 16'h7FFF};
        for (int s = 0; s < 5; s++) begin
            write_reg(CFG_PAGE_WORDS, 16'(pw_set[s]));
            write_reg(CFG_PERSISTENT_SLOTS, ps_set[s]);
            repeat (35)
                send_random_word($urandom_range(0, 3) != 0);
        end
        // upper data bits are dropped for page_words; spare indexes change nothing
        write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(CFG_PAGE_WORDS, 16'hFE20);
        repeat (20)
            send_random_word(1'b1);
    endtask

    task automatic test_output_backpressure();
        gaps_off    = 1'b1;
        hold_length = HOLD_LONG;
        hold_asks++;
        repeat (50)
            send_random_word(1'b1);
        gaps_off = 1'b0;
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_PAGE_WORDS, CFG_DATA_W'($urandom_range(32, 256)));
            if (ph % 2 == 0)
                write_reg(CFG_PERSISTENT_SLOTS, persist_next + 16'($urandom_range(0, 40)));
            else
                write_reg(CFG_PERSISTENT_SLOTS, CFG_DATA_W'($urandom_range(0, 65535)));
            repeat (220)
                send_random_word($urandom_range(0, 3) != 0);
        end
    endtask

    initial begin : receiver
        t_rx_pattern rx_mode;
        int mode_left;
        int hold_left;
        int hold_taken;
        int tick;
        rx_mode    = RX_STEADY;
        mode_left  = 0;
        hold_left  = 0;
        hold_taken = 0;
        tick       = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (hold_taken != hold_asks) begin
                hold_taken = hold_asks;
                hold_left  = hold_length;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_pattern'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (rx_mode)
                    RX_STEADY:  rsp_if.ready <= 1'b1;
                    RX_LIGHT:   rsp_if.ready <= ($urandom_range(0, 3) != 0);
                    RX_HEAVY:   rsp_if.ready <= ($urandom_range(0, 9) < 3);
                    default:    rsp_if.ready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_slot_grant want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            err_seen[rsp_if.error_code]++;
            if (slot_grants_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected response slot=%0d err=%0d", $time,
                             rsp_if.slot_index, rsp_if.error_code);
            end else begin
                want = slot_grants_due.pop_front();
                if (rsp_if.slot_index !== want.slot || rsp_if.error_code !== want.err) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: mismatch slot exp=%0d got=%0d, err exp=%0d got=%0d",
                                 $time, want.slot, rsp_if.slot_index, want.err,
                                 rsp_if.error_code);
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        int quiet_cycles;
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("** descriptor_page_allocator_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        int leftover;
        i_rst_n                <= 1'b0;
        req_if.valid           <= 1'b0;
        req_if.command         <= CMD_ALLOC_DYN;
        req_if.count           <= '0;
        req_if.fence_value     <= '0;
        req_if.completed_value <= '0;
        cfg_if.valid           <= 1'b0;
        cfg_if.index           <= CFG_PAGE_WORDS;
        cfg_if.data            <= '0;
        for (int i = 0; i < 4; i++) begin
            cmd_seen[i] = 0;
            err_seen[i] = 0;
        end
        reset_allocator_model();
        fence_now  = $urandom();
        fence_done = fence_now;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_register_settings();
        test_output_backpressure();
        test_random_traffic();

        wait_until_idle();
        repeat (60) @(posedge i_clk);
        leftover = slot_grants_due.size();
        if (leftover != 0)
            $display("%0d expected responses never arrived", leftover);
        $display("Ran %0d words (%0d dynamic, %0d release, %0d persistent, %0d unused)",
                 cmd_seen[0] + cmd_seen[1] + cmd_seen[2] + cmd_seen[3], cmd_seen[CMD_ALLOC_DYN],
                 cmd_seen[CMD_RELEASE], cmd_seen[CMD_ALLOC_PERS], cmd_seen[CMD_UNUSED]);
        $display("over %0d reg writes; responses: %0d ok, %0d no page, %0d persistent full, %0d oversize",
                 reg_writes, err_seen[ERR_OK], err_seen[ERR_NO_PAGE], err_seen[ERR_PERS_FULL],
                 err_seen[ERR_OVERSIZE]);
        if (fail_count == 0 && leftover == 0)
            $display("** descriptor_page_allocator_unit: PASSED **");
        else
            $display("** descriptor_page_allocator_unit: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dpa_pkg.sv
rtl/dpa_intf.sv
rtl/dpa_ctrl.sv
rtl/dpa_dp.sv
rtl/descriptor_page_allocator_unit.sv
tb/tb_descriptor_page_allocator_unit.sv
